### hw/rtl/aabb_pkg.sv
// Shared constants and types for the bounding-box accumulator.
package aabb_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int GROUP_BITS_DEF = 16;

  // configuration port
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_WANTED_GROUP    = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GROUP_FILTER_ON = 1'd1;

  // per-item control handed to each axis unit
  typedef struct packed {
    logic step;   // item leaves the input register this cycle
    logic take;   // item passes the group filter
    logic first;  // no point gathered so far in this set
    logic last;   // item closes the set
  } axis_ctl_t;

endpackage

### hw/rtl/aabb_if.sv
// Valid/ready channels for points in and boxes out.
interface aabb_point_if #(
  parameter int COORD_BITS = 16,
  parameter int GROUP_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;
  logic        [GROUP_BITS-1:0] group_id;
  logic                         last_point;

  modport source (output valid, coord_x, coord_y, coord_z, group_id, last_point,
                  input ready);
  modport sink   (input valid, coord_x, coord_y, coord_z, group_id, last_point,
                  output ready);
endinterface

interface aabb_box_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] min_x;
  logic signed [COORD_BITS-1:0] max_x;
  logic signed [COORD_BITS-1:0] min_y;
  logic signed [COORD_BITS-1:0] max_y;
  logic signed [COORD_BITS-1:0] min_z;
  logic signed [COORD_BITS-1:0] max_z;
  logic signed [COORD_BITS:0]   center_x2;
  logic signed [COORD_BITS:0]   center_y2;
  logic signed [COORD_BITS:0]   center_z2;
  logic        [COORD_BITS-1:0] width_x;
  logic        [COORD_BITS-1:0] width_y;
  logic        [COORD_BITS-1:0] width_z;

  modport source (output valid, min_x, max_x, min_y, max_y, min_z, max_z,
                  center_x2, center_y2, center_z2, width_x, width_y, width_z,
                  input ready);
  modport sink   (input valid, min_x, max_x, min_y, max_y, min_z, max_z,
                  center_x2, center_y2, center_z2, width_x, width_y, width_z,
                  output ready);
endinterface

### hw/rtl/aabb_axis.sv
// One axis: running min/max registers and the box terms for the current item.
module aabb_axis import aabb_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  axis_ctl_t                    ctl,
  input  logic signed [COORD_BITS-1:0] coord,
  output logic signed [COORD_BITS-1:0] lo_out,
  output logic signed [COORD_BITS-1:0] hi_out,
  output logic signed [COORD_BITS:0]   center2,
  output logic        [COORD_BITS-1:0] width
);

  logic signed [COORD_BITS-1:0] run_lo;
  logic signed [COORD_BITS-1:0] run_hi;
  logic signed [COORD_BITS-1:0] run_lo_next;
  logic signed [COORD_BITS-1:0] run_hi_next;
  logic                         empty;

  always_comb begin
    run_lo_next = run_lo;
    run_hi_next = run_hi;
    if (ctl.take) begin
      if (ctl.first || (coord < run_lo)) begin
        run_lo_next = coord;
      end
      if (ctl.first || (coord > run_hi)) begin
        run_hi_next = coord;
      end
    end
  end

  // state is zero while no point is held, so min, max and center come out 0
  assign empty   = ctl.first && !ctl.take;
  assign lo_out  = run_lo_next;
  assign hi_out  = run_hi_next;
  assign center2 = {run_lo_next[COORD_BITS-1], run_lo_next}
                 + {run_hi_next[COORD_BITS-1], run_hi_next};
  assign width   = empty ? COORD_BITS'(1) : COORD_BITS'(run_hi_next - run_lo_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      run_lo <= '0;
      run_hi <= '0;
    end else if (ctl.step) begin
      if (ctl.last) begin
        run_lo <= '0;
        run_hi <= '0;
      end else begin
        run_lo <= run_lo_next;
        run_hi <= run_hi_next;
      end
    end
  end

endmodule

### hw/rtl/aabb_group_accumulator_core.sv
// Top level: group-filtered axis-aligned bounding box over a point stream.
// A box is offered from the result register once its last point leaves the
//   input register; the min/max compare-select and the center/width adders sit
//   between the input and result registers. Throughput: 1 point per cycle,
//   except that a last point stalls while the result register stays full.
// Reset (rst, synchronous): clears config, running box, point flag, valids.
module aabb_group_accumulator_core import aabb_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int GROUP_BITS = GROUP_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  aabb_point_if.sink                points,
  aabb_box_if.source                box
);

  // ---------------------------------------------------------------- config
  logic [CFG_DATA_BITS-1:0] wanted_group;
  logic                     group_filter_on;
  logic [GROUP_BITS-1:0]    wanted_cmp;

  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_group    <= '0;
      group_filter_on <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WANTED_GROUP:    wanted_group    <= cfg_data;
        REG_GROUP_FILTER_ON: group_filter_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // only the low GROUP_BITS of the wanted group take part in the compare
  generate
    if (GROUP_BITS <= CFG_DATA_BITS) begin : g_grp_narrow
      assign wanted_cmp = wanted_group[GROUP_BITS-1:0];
    end else begin : g_grp_wide
      assign wanted_cmp = {{(GROUP_BITS-CFG_DATA_BITS){1'b0}}, wanted_group};
    end
  endgenerate

  // ---------------------------------------------------------- input register
  logic                         s1_valid;
  logic signed [COORD_BITS-1:0] s1_x;
  logic signed [COORD_BITS-1:0] s1_y;
  logic signed [COORD_BITS-1:0] s1_z;
  logic        [GROUP_BITS-1:0] s1_group;
  logic                         s1_last;
  logic                         advance;
  logic                         out_valid;

  // a non-last item never needs the result register, so it moves freely;
  // a last item waits until the result register is free or being drained
  assign advance      = s1_valid && (!s1_last || !out_valid || box.ready);
  assign points.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (points.ready) begin
      s1_valid <= points.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (points.valid && points.ready) begin
      s1_x     <= points.coord_x;
      s1_y     <= points.coord_y;
      s1_z     <= points.coord_z;
      s1_group <= points.group_id;
      s1_last  <= points.last_point;
    end
  end

  // ---------------------------------------------------------- accumulation
  logic      have_point;
  logic      take;
  axis_ctl_t ctl;

  assign take = !group_filter_on || (s1_group == wanted_cmp);

  always_comb begin
    ctl.step  = advance;
    ctl.take  = take;
    ctl.first = !have_point;
    ctl.last  = s1_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_point <= 1'b0;
    end else if (advance) begin
      have_point <= s1_last ? 1'b0 : (have_point || take);
    end
  end

  logic signed [COORD_BITS-1:0] lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
  logic signed [COORD_BITS:0]   c2_x, c2_y, c2_z;
  logic        [COORD_BITS-1:0] w_x, w_y, w_z;

  aabb_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
    .clk(clk), .rst(rst), .ctl(ctl), .coord(s1_x),
    .lo_out(lo_x), .hi_out(hi_x), .center2(c2_x), .width(w_x)
  );

  aabb_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
    .clk(clk), .rst(rst), .ctl(ctl), .coord(s1_y),
    .lo_out(lo_y), .hi_out(hi_y), .center2(c2_y), .width(w_y)
  );

  aabb_axis #(.COORD_BITS(COORD_BITS)) u_axis_z (
    .clk(clk), .rst(rst), .ctl(ctl), .coord(s1_z),
    .lo_out(lo_z), .hi_out(hi_z), .center2(c2_z), .width(w_z)
  );

  // --------------------------------------------------------- result register
  logic signed [COORD_BITS-1:0] r_min_x, r_max_x, r_min_y, r_max_y, r_min_z, r_max_z;
  logic signed [COORD_BITS:0]   r_c2_x, r_c2_y, r_c2_z;
  logic        [COORD_BITS-1:0] r_w_x, r_w_y, r_w_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_last) begin
      out_valid <= 1'b1;
    end else if (box.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last) begin
      r_min_x <= lo_x;
      r_max_x <= hi_x;
      r_min_y <= lo_y;
      r_max_y <= hi_y;
      r_min_z <= lo_z;
      r_max_z <= hi_z;
      r_c2_x  <= c2_x;
      r_c2_y  <= c2_y;
      r_c2_z  <= c2_z;
      r_w_x   <= w_x;
      r_w_y   <= w_y;
      r_w_z   <= w_z;
    end
  end

  assign box.valid     = out_valid;
  assign box.min_x     = r_min_x;
  assign box.max_x     = r_max_x;
  assign box.min_y     = r_min_y;
  assign box.max_y     = r_max_y;
  assign box.min_z     = r_min_z;
  assign box.max_z     = r_max_z;
  assign box.center_x2 = r_c2_x;
  assign box.center_y2 = r_c2_y;
  assign box.center_z2 = r_c2_z;
  assign box.width_x   = r_w_x;
  assign box.width_y   = r_w_y;
  assign box.width_z   = r_w_z;

endmodule
